// File: hdl/rps_pkg.sv
// package: profile tables, sizes and controller/datapath command and status types
package rps_pkg;

  localparam int POINT_COUNT   = 10;
  localparam int NUM_PROFILES  = 3;
  localparam int PNT_IW        = $clog2(POINT_COUNT);
  localparam int PRF_IW        = 2;

  localparam logic [8:0] TIME_CEIL = 9'd500;
  localparam logic [7:0] TEMP_LOW  = 8'd50;
  localparam logic [7:0] TEMP_HIGH = 8'd250;

  // product of time offset (9 bits) and temperature step magnitude (8 bits)
  localparam int PROD_W    = 17;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  localparam logic [8:0] PT_TIME [NUM_PROFILES][POINT_COUNT] = '{
    '{9'd0, 9'd130, 9'd220, 9'd320, 9'd340, 9'd500, 9'd500, 9'd500, 9'd500, 9'd500},
    '{9'd0, 9'd60,  9'd150, 9'd260, 9'd280, 9'd420, 9'd500, 9'd500, 9'd500, 9'd500},
    '{9'd0, 9'd50,  9'd140, 9'd200, 9'd220, 9'd310, 9'd500, 9'd500, 9'd500, 9'd500}
  };

  localparam logic [7:0] PT_TEMP [NUM_PROFILES][POINT_COUNT] = '{
    '{8'd50, 8'd150, 8'd175, 8'd250, 8'd250, 8'd50, 8'd50, 8'd50, 8'd50, 8'd50},
    '{8'd50, 8'd100, 8'd150, 8'd235, 8'd235, 8'd50, 8'd50, 8'd50, 8'd50, 8'd50},
    '{8'd50, 8'd90,  8'd130, 8'd165, 8'd165, 8'd50, 8'd50, 8'd50, 8'd50, 8'd50}
  };

  localparam logic [8:0] COOL_START [NUM_PROFILES] = '{9'd340, 9'd280, 9'd220};

  typedef struct packed {
    logic load;
    logic search_step;
    logic mul;
    logic div_step;
    logic finish;
  } rps_cmd_t;

  typedef struct packed {
    logic              search_done;
    logic              div_done;
    logic [PRF_IW-1:0] profile;
  } rps_sts_t;

endpackage

// File: hdl/rps_in_if.sv
// input channel: elapsed time beats
interface rps_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_time;

  modport source (output valid, output elapsed_time, input ready);
  modport sink (input valid, input elapsed_time, output ready);
endinterface

// File: hdl/rps_out_if.sv
// result channel: setpoint and cooldown start beats
interface rps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] setpoint_temp;
  logic [8:0] cooldown_start;

  modport source (output valid, output setpoint_temp, output cooldown_start, input ready);
  modport sink (input valid, input setpoint_temp, input cooldown_start, output ready);
endinterface

// File: hdl/reflow_profile_setpoint_top.sv
// top level: reflow profile setpoint lookup with valid/ready channels
//
// in_bus carries one elapsed time in seconds per beat; out_bus returns one
// beat per input with the interpolated setpoint (50..250 degrees) and the
// active profile's cooldown start time. cfg_we/cfg_wdata select the profile;
// values past the last profile are dropped. Write only while idle.
//
// One item is worked at a time. After acceptance the segment search walks
// the profile points one per cycle, then the multiply step, a 17-step
// restoring divider and the result load, which waits while a stalled
// receiver still holds the result register. The result becomes valid in the
// same cycle that in_bus.ready returns. The divider takes most of the time
// of an item.
//
// Reset (rst_n low, synchronous) returns to idle, drops any pending result
// and selects profile 0. A stalled receiver holds the result register; the
// next item may be accepted and worked meanwhile, and it waits at the end
// until the register is taken.
module reflow_profile_setpoint_top (
  input  logic                      clk,
  input  logic                      rst_n,
  rps_in_if.sink                    in_bus,
  rps_out_if.source                 out_bus,
  input  logic                      cfg_we,
  input  logic [rps_pkg::PRF_IW-1:0] cfg_wdata
);

  rps_pkg::rps_cmd_t cmd;
  rps_pkg::rps_sts_t sts;

  rps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rps_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .elapsed_time   (in_bus.elapsed_time),
    .cmd            (cmd),
    .sts            (sts),
    .setpoint_temp  (out_bus.setpoint_temp),
    .cooldown_start (out_bus.cooldown_start)
  );

  // one item in flight: no second accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("input accepted while an item is in flight");

  // a fresh result is always inside the clamp window
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> (out_bus.setpoint_temp >= rps_pkg::TEMP_LOW &&
                              out_bus.setpoint_temp <= rps_pkg::TEMP_HIGH))
    else $error("setpoint outside clamp window");

  // out-of-range profile writes leave the selection alone
  a_cfg_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && ({1'b0, cfg_wdata} >= (rps_pkg::PRF_IW + 1)'(rps_pkg::NUM_PROFILES)))
    |=> $stable(sts.profile))
    else $error("out-of-range profile write took effect");

  // commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("controller issued overlapping commands");

endmodule

// File: hdl/rps_ctrl.sv
// controller: sequences search, multiply, serial divide and result load
module rps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rps_pkg::rps_cmd_t cmd,
  input  rps_pkg::rps_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIV    = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.search_done) begin
          state_nxt = S_MUL;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        // result register free or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: hdl/rps_dp.sv
// datapath: profile register, segment search, multiplier, restoring divider, result register
module rps_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [rps_pkg::PRF_IW-1:0] cfg_wdata,
  input  logic [15:0]               elapsed_time,
  input  rps_pkg::rps_cmd_t         cmd,
  output rps_pkg::rps_sts_t         sts,
  output logic [7:0]                setpoint_temp,
  output logic [8:0]                cooldown_start
);

  logic [rps_pkg::PRF_IW-1:0]  profile_r;
  logic [8:0]                  t_r;
  logic [rps_pkg::PNT_IW-1:0]  k_r;
  logic [rps_pkg::PNT_IW-1:0]  k_prev;
  logic [rps_pkg::PROD_W-1:0]  q_r;
  logic [8:0]                  rem_r;
  logic [8:0]                  span_r;
  logic [7:0]                  v0_r;
  logic                        neg_r;
  logic                        zero_r;
  logic [rps_pkg::DIV_CW-1:0]  cnt_r;
  logic [7:0]                  temp_r;
  logic [8:0]                  cool_r;

  logic [8:0]                  t0, t1;
  logic [7:0]                  v0, v1, dmag;
  logic [8:0]                  dt;
  logic [9:0]                  trial;
  logic                        ge;
  logic signed [17:0]          qs, v0s, vs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      profile_r <= '0;
    end else if (cfg_we &&
                 ({1'b0, cfg_wdata} < (rps_pkg::PRF_IW + 1)'(rps_pkg::NUM_PROFILES))) begin
      profile_r <= cfg_wdata;
    end
  end

  assign k_prev = k_r - 1'b1;
  assign t0     = rps_pkg::PT_TIME[profile_r][k_prev];
  assign t1     = rps_pkg::PT_TIME[profile_r][k_r];
  assign v0     = rps_pkg::PT_TEMP[profile_r][k_prev];
  assign v1     = rps_pkg::PT_TEMP[profile_r][k_r];
  assign dt     = t_r - t0;
  assign dmag   = (v1 < v0) ? (v0 - v1) : (v1 - v0);

  assign sts.search_done = !((k_r < rps_pkg::PNT_IW'(rps_pkg::POINT_COUNT - 1)) && (t_r > t1));
  assign sts.div_done    = (cnt_r == '0);
  assign sts.profile     = profile_r;

  // one quotient bit per step
  assign trial = {rem_r, q_r[rps_pkg::PROD_W-1]};
  assign ge    = (trial >= {1'b0, span_r});

  assign qs  = signed'({1'b0, q_r});
  assign v0s = signed'({10'd0, v0_r});
  always_comb begin
    if (zero_r) begin
      vs = v0s;
    end else if (neg_r) begin
      vs = v0s - qs;
    end else begin
      vs = v0s + qs;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r <= (elapsed_time > {7'd0, rps_pkg::TIME_CEIL}) ? rps_pkg::TIME_CEIL
                                                          : elapsed_time[8:0];
      k_r <= rps_pkg::PNT_IW'(1);
    end
    if (cmd.search_step) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.mul) begin
      q_r    <= dt * dmag;
      rem_r  <= '0;
      span_r <= t1 - t0;
      v0_r   <= v0;
      neg_r  <= (v1 < v0);
      zero_r <= (t1 == t0);
      cnt_r  <= rps_pkg::DIV_CW'(rps_pkg::DIV_STEPS);
    end
    if (cmd.div_step) begin
      rem_r <= ge ? 9'(trial - {1'b0, span_r}) : trial[8:0];
      q_r   <= {q_r[rps_pkg::PROD_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.finish) begin
      if (vs < signed'({10'd0, rps_pkg::TEMP_LOW})) begin
        temp_r <= rps_pkg::TEMP_LOW;
      end else if (vs > signed'({10'd0, rps_pkg::TEMP_HIGH})) begin
        temp_r <= rps_pkg::TEMP_HIGH;
      end else begin
        temp_r <= vs[7:0];
      end
      cool_r <= rps_pkg::COOL_START[profile_r];
    end
  end

  assign setpoint_temp  = temp_r;
  assign cooldown_start = cool_r;

endmodule

// File: verif/reflow_profile_setpoint_top_tb.sv
// testbench: reflow profile setpoint lookup checked against a local interpolation predictor
module reflow_profile_setpoint_top_tb;

  localparam int NPTS         = 10;
  localparam int NPRF         = 3;
  localparam int SECS_CLAMP   = 500;
  localparam int DEGC_LOW     = 50;
  localparam int DEGC_HIGH    = 250;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;
  localparam int RAND_PER_SET = 80;

  localparam logic [rps_pkg::PRF_IW-1:0] PRF_REFLOW_A = 2'd0;
  localparam logic [rps_pkg::PRF_IW-1:0] PRF_REFLOW_B = 2'd1;
  localparam logic [rps_pkg::PRF_IW-1:0] PRF_REFLOW_C = 2'd2;
  localparam logic [rps_pkg::PRF_IW-1:0] PRF_INVALID  = 2'd3;

  localparam int PT_SECS [NPRF][NPTS] = '{
    '{0, 130, 220, 320, 340, 500, 500, 500, 500, 500},
    '{0, 60,  150, 260, 280, 420, 500, 500, 500, 500},
    '{0, 50,  140, 200, 220, 310, 500, 500, 500, 500}
  };
  localparam int PT_DEGC [NPRF][NPTS] = '{
    '{50, 150, 175, 250, 250, 50, 50, 50, 50, 50},
    '{50, 100, 150, 235, 235, 50, 50, 50, 50, 50},
    '{50, 90,  130, 165, 165, 50, 50, 50, 50, 50}
  };
  localparam int COOL_SECS [NPRF] = '{340, 280, 220};

  typedef struct packed {
    logic [7:0] temp;
    logic [8:0] cool;
  } setpoint_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [rps_pkg::PRF_IW-1:0] cfg_wdata;

  rps_in_if  in_bus ();
  rps_out_if out_bus ();

  setpoint_t pending_setpoints [$];
  int  active_prof = 0;
  bit  src_idle_on = 1'b1;
  bit  snk_idle_on = 1'b1;
  // bumped by the stimulus side, followed by the receiver process
  int  hold_reqs = 0;

  int  mismatches = 0;
  int  unexpected = 0;
  int  leftover   = 0;
  int  beats_sent = 0;
  int  beats_checked = 0;
  int  cfg_writes = 0;
  int  cfg_rejected = 0;
  int  prof_beats [NPRF] = '{0, 0, 0};
  int  quiet_cycles = 0;

  always #5 clk = ~clk;

  reflow_profile_setpoint_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic setpoint_t calc_setpoint(input logic [15:0] secs, input int prof);
    int t;
    int k;
    int span;
    int v;
    setpoint_t r;
    t = (secs > SECS_CLAMP) ? SECS_CLAMP : int'(secs);
    // first point at or past t, never beyond the last one
    k = 1;
    while (k < NPTS - 1 && t > PT_SECS[prof][k]) k++;
    span = PT_SECS[prof][k] - PT_SECS[prof][k-1];
    if (span == 0) begin
      v = PT_DEGC[prof][k-1];
    end else begin
      v = (t - PT_SECS[prof][k-1]) * (PT_DEGC[prof][k] - PT_DEGC[prof][k-1]) / span
          + PT_DEGC[prof][k-1];
    end
    if (v < DEGC_LOW) v = DEGC_LOW;
    if (v > DEGC_HIGH) v = DEGC_HIGH;
    r.temp = v[7:0];
    r.cool = COOL_SECS[prof][8:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_secs(input int prof);
    int near;
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom_range(0, 65535));
      2, 3, 4: begin
        // land on or next to a breakpoint of the active profile
        near = PT_SECS[prof][$urandom_range(0, NPTS - 1)] + $urandom_range(0, 2) - 1;
        if (near < 0) near = 0;
        return 16'(near);
      end
      default: return 16'($urandom_range(0, 520));
    endcase
  endfunction

  task automatic send_time(input logic [15:0] secs);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.elapsed_time <= secs;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_setpoints.push_back(calc_setpoint(secs, active_prof));
    beats_sent++;
    prof_beats[active_prof]++;
  endtask

  task automatic set_profile(input logic [rps_pkg::PRF_IW-1:0] sel);
    in_bus.valid <= 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    if (sel < NPRF) active_prof = sel;
    else cfg_rejected++;
  endtask

  task automatic test_directed_profiles();
    // reset profile: ends, breakpoints, clamp above 500, all-ones time
    send_time(16'd0);
    send_time(16'd65);
    send_time(16'd130);
    send_time(16'd131);
    send_time(16'd340);
    send_time(16'd500);
    send_time(16'd501);
    send_time(16'hFFFF);
    set_profile(PRF_REFLOW_C);
    send_time(16'd50);
    send_time(16'd219);
    send_time(16'd310);
    send_time(16'd311);
    send_time(16'h8000);
    // out-of-range select must leave the last profile active
    set_profile(PRF_INVALID);
    send_time(16'd200);
    send_time(16'd311);
    set_profile(PRF_REFLOW_B);
    send_time(16'd60);
    send_time(16'd259);
    send_time(16'd280);
    send_time(16'd420);
    send_time(16'd421);
    send_time(16'd500);
  endtask

  task automatic test_random_times();
    logic [rps_pkg::PRF_IW-1:0] order [5];
    order = '{PRF_REFLOW_A, PRF_REFLOW_C, PRF_REFLOW_B, PRF_INVALID, PRF_REFLOW_A};
    foreach (order[i]) begin
      if (i == 4) set_profile(2'($urandom_range(0, 3)));
      else set_profile(order[i]);
      // one set runs back to back on both sides
      src_idle_on = (i != 2);
      snk_idle_on = (i != 2);
      repeat (RAND_PER_SET) send_time(pick_secs(active_prof));
    end
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  task automatic test_receiver_hold();
    set_profile(PRF_REFLOW_A);
    hold_reqs++;
    src_idle_on = 1'b0;
    repeat (12) send_time(pick_secs(active_prof));
    src_idle_on = 1'b1;
  endtask

  // result side: random stalls per beat, a long hold on request
  initial begin
    int stall_left;
    int hold_left;
    int hold_seen;
    setpoint_t want;
    setpoint_t got;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got.temp = out_bus.setpoint_temp;
        got.cool = out_bus.cooldown_start;
        beats_checked++;
        if (pending_setpoints.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= MAX_REPORTS)
            $display("unexpected result beat: temp=%0d cool=%0d", got.temp, got.cool);
        end else begin
          want = pending_setpoints.pop_front();
          if (got.temp !== want.temp || got.cool !== want.cool) begin
            mismatches++;
            if (mismatches + unexpected <= MAX_REPORTS)
              $display("result mismatch: temp exp %0d got %0d, cool exp %0d got %0d",
                       want.temp, got.temp, want.cool, got.cool);
          end
        end
        stall_left = snk_idle_on ? $urandom_range(0, 6) : 0;
      end
      if (hold_reqs != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_reqs;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no beat moved for %0d cycles", QUIET_LIMIT);
      $display("FAIL reflow_profile_setpoint_top");
      $finish;
    end
  end

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.elapsed_time <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_profiles();
    test_random_times();
    test_receiver_hold();

    in_bus.valid <= 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    leftover = pending_setpoints.size();

    $display("%0d time beats (profiles 0/1/2: %0d/%0d/%0d), %0d checked, %0d mismatches",
             beats_sent, prof_beats[0], prof_beats[1], prof_beats[2], beats_checked,
             mismatches);
    $display("%0d profile writes (%0d out of range), one %0d-cycle receiver hold",
             cfg_writes, cfg_rejected, HOLD_CYCLES);
    if (mismatches == 0 && unexpected == 0 && leftover == 0) begin
      $display("PASS reflow_profile_setpoint_top");
    end else begin
      $display("FAIL reflow_profile_setpoint_top");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/rps_pkg.sv
hdl/rps_in_if.sv
hdl/rps_out_if.sv
hdl/rps_ctrl.sv
hdl/rps_dp.sv
hdl/reflow_profile_setpoint_top.sv
verif/reflow_profile_setpoint_top_tb.sv
